// ===== rtl/lbp_pkg.sv =====
// ----------------------------------------------------------------------------
// lbp_pkg
// Shared widths, defaults and operation codes of the LSB-first bit packer.
// ----------------------------------------------------------------------------
package lbp_pkg;

	localparam int unsigned DEFAULT_BUFFER_DEPTH = 16;

	localparam int unsigned OP_W    = 1;
	localparam int unsigned COUNT_W = 7;
	localparam int unsigned VALUE_W = 64;
	localparam int unsigned BYTE_W  = 8;
	localparam int unsigned SPACE_W = 8;

	localparam int unsigned MAX_COUNT = 64;

	localparam logic [OP_W-1:0] OP_APPEND = 1'b0;
	localparam logic [OP_W-1:0] OP_FLUSH  = 1'b1;

endpackage

// ===== rtl/lbp_in_if.sv =====
// ----------------------------------------------------------------------------
// lbp_in_if
// Input channel of the bit packer: operation, bit count and field value.
// ----------------------------------------------------------------------------
interface lbp_in_if;

	logic                             valid;
	logic                             ready;
	logic [lbp_pkg::OP_W-1:0]         op;
	logic [lbp_pkg::COUNT_W-1:0]      bit_count;
	logic [lbp_pkg::VALUE_W-1:0]      field_value;

	modport source (output valid, output op, output bit_count, output field_value,
		input ready);
	modport sink (input valid, input op, input bit_count, input field_value,
		output ready);

endinterface

// ===== rtl/lbp_out_if.sv =====
// ----------------------------------------------------------------------------
// lbp_out_if
// Output channel of the bit packer: emitted byte, free space and last mark.
// ----------------------------------------------------------------------------
interface lbp_out_if;

	logic                             valid;
	logic                             ready;
	logic                             byte_valid;
	logic [lbp_pkg::BYTE_W-1:0]       out_byte;
	logic [lbp_pkg::SPACE_W-1:0]      space_bits;
	logic                             last;

	modport source (output valid, output byte_valid, output out_byte, output space_bits,
		output last, input ready);
	modport sink (input valid, input byte_valid, input out_byte, input space_bits,
		input last, output ready);

endinterface

// ===== rtl/lsb_first_bit_packer.sv =====
// ----------------------------------------------------------------------------
// lsb_first_bit_packer
// Packs variable-width fields LSB first into a circular byte ring.
// ----------------------------------------------------------------------------
// One item is handled at a time; in_ch.ready is high only while idle. An
// append works through the bytes it touches one at a time (up to nine for
// 64 bits), since one shared insert unit merges at most one byte's worth of
// bits per cycle while packing. When the ring wraps, or on a flush, the
// complete bytes are copied out of the ring memory at one byte per cycle,
// through its single read port. A final state then sets the free space, and
// each result needs an emit buffer read, then the output register, plus any
// stall on out_ch. Every item gives at least one result, the last one marked
// with last; an item that emits no byte gives one result with byte_valid low.
// ----------------------------------------------------------------------------
module lsb_first_bit_packer #(
	parameter int unsigned BUFFER_DEPTH = lbp_pkg::DEFAULT_BUFFER_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	lbp_in_if.sink      in_ch,
	lbp_out_if.source   out_ch
);

	localparam int unsigned IW = $clog2(BUFFER_DEPTH);
	localparam int unsigned EW = $clog2(BUFFER_DEPTH + 1);
	localparam int unsigned SW = (IW + 4 > 9) ? IW + 4 : 9;
	localparam logic [IW-1:0] LAST_SLOT = IW'(BUFFER_DEPTH - 1);
	localparam logic [EW-1:0] EMIT_CAP  = EW'(BUFFER_DEPTH);
	localparam logic [IW:0]   DEPTH_W   = (IW+1)'(BUFFER_DEPTH);
	localparam logic [lbp_pkg::COUNT_W-1:0] COUNT_CAP = lbp_pkg::COUNT_W'(lbp_pkg::MAX_COUNT);

	typedef enum logic [2:0] {
		S_IDLE,
		S_PACK,
		S_DRAIN,
		S_FINAL,
		S_FETCH,
		S_SHOW
	} state_t;

	state_t                          state_q;
	logic [IW-1:0]                   write_q;
	logic [IW-1:0]                   read_q;
	logic [3:0]                      bits_q;
	logic [lbp_pkg::COUNT_W-1:0]     n_q;
	logic                            from_pack_q;
	logic [EW-1:0]                   ecount_q;
	logic [IW-1:0]                   oidx_q;
	logic                            bvalid_q;
	logic                            last_q;
	logic [lbp_pkg::SPACE_W-1:0]     space_q;
	logic [7:0]                      cur_q;
	logic [lbp_pkg::VALUE_W-1:0]     val_q;
	logic                            rd_vld_s1;
	logic [7:0]                      rd_byte_s1;
	logic [7:0]                      ebuf_rd_q;

	logic [7:0]                      ring_mem [BUFFER_DEPTH];
	logic [7:0]                      ebuf_mem [BUFFER_DEPTH];

	logic                            in_xfer;
	logic [IW-1:0]                   nxt_write;
	logic [IW-1:0]                   nxt_read;
	logic [3:0]                      take;
	logic [2:0]                      shift;
	logic [8:0]                      ones;
	logic [7:0]                      mask8;
	logic [7:0]                      byte_next;
	logic [lbp_pkg::COUNT_W-1:0]     n_next;
	logic [3:0]                      bits_next;
	logic [IW:0]                     free_slots;
	logic [SW-1:0]                   space_wide;
	logic [lbp_pkg::SPACE_W-1:0]     space_sat;
	logic                            drain_rd;

	assign in_xfer   = in_ch.valid && (state_q == S_IDLE);
	assign nxt_write = (write_q == LAST_SLOT) ? '0 : write_q + 1'b1;
	assign nxt_read  = (read_q == LAST_SLOT) ? '0 : read_q + 1'b1;

	assign take      = (n_q >= lbp_pkg::COUNT_W'(bits_q)) ? bits_q : n_q[3:0];
	assign shift     = 3'(4'd8 - bits_q);
	assign ones      = (9'd1 << take) - 9'd1;
	assign mask8     = ones[7:0] << shift;
	assign byte_next = (cur_q & ~mask8) | ((val_q[7:0] << shift) & mask8);
	assign n_next    = n_q - lbp_pkg::COUNT_W'(take);
	assign bits_next = bits_q - take;

	assign free_slots = (read_q > write_q) ? {1'b0, read_q} - {1'b0, write_q} - 1'b1
		: {1'b0, read_q} + DEPTH_W - {1'b0, write_q} - 1'b1;
	assign space_wide = SW'(bits_q) + SW'({free_slots, 3'b000});
	assign space_sat  = (space_wide > SW'(255)) ? 8'hFF : space_wide[7:0];

	assign drain_rd = (state_q == S_DRAIN) && (read_q != write_q);

	assign in_ch.ready       = (state_q == S_IDLE);
	assign out_ch.valid      = (state_q == S_SHOW);
	assign out_ch.byte_valid = bvalid_q;
	assign out_ch.out_byte   = ebuf_rd_q & {8{bvalid_q}};
	assign out_ch.space_bits = space_q;
	assign out_ch.last       = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			write_q     <= '0;
			read_q      <= '0;
			bits_q      <= 4'd8;
			n_q         <= '0;
			from_pack_q <= 1'b0;
			ecount_q    <= '0;
			oidx_q      <= '0;
			bvalid_q    <= 1'b0;
			last_q      <= 1'b0;
			space_q     <= '0;
			rd_vld_s1   <= 1'b0;
		end else begin
			rd_vld_s1 <= drain_rd;
			if (rd_vld_s1 && (ecount_q < EMIT_CAP)) begin
				ecount_q <= ecount_q + 1'b1;
			end
			case (state_q)
				S_IDLE: begin
					if (in_ch.valid) begin
						ecount_q <= '0;
						oidx_q   <= '0;
						if (in_ch.op == lbp_pkg::OP_FLUSH) begin
							from_pack_q <= 1'b0;
							state_q     <= S_DRAIN;
						end else begin
							n_q <= (in_ch.bit_count > COUNT_CAP) ? COUNT_CAP
								: in_ch.bit_count;
							state_q <= (in_ch.bit_count == '0) ? S_FINAL : S_PACK;
						end
					end
				end
				S_PACK: begin
					n_q    <= n_next;
					bits_q <= (bits_next == 4'd0) ? 4'd8 : bits_next;
					if (bits_next == 4'd0 && nxt_write == read_q) begin
						from_pack_q <= 1'b1;
						state_q     <= S_DRAIN;
					end else begin
						if (bits_next == 4'd0) begin
							write_q <= nxt_write;
						end
						if (n_next == '0) begin
							state_q <= S_FINAL;
						end
					end
				end
				S_DRAIN: begin
					if (read_q != write_q) begin
						read_q <= nxt_read;
					end else begin
						if (from_pack_q) begin
							write_q <= nxt_write;
						end
						state_q <= (from_pack_q && n_q != '0) ? S_PACK : S_FINAL;
					end
				end
				S_FINAL: begin
					space_q <= space_sat;
					state_q <= S_FETCH;
				end
				S_FETCH: begin
					bvalid_q <= (ecount_q != '0);
					last_q   <= (ecount_q == '0) || (EW'(oidx_q) + 1'b1 == ecount_q);
					state_q  <= S_SHOW;
				end
				S_SHOW: begin
					if (out_ch.ready) begin
						if (last_q) begin
							state_q <= S_IDLE;
						end else begin
							oidx_q  <= oidx_q + 1'b1;
							state_q <= S_FETCH;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			val_q <= in_ch.field_value;
		end else if (state_q == S_PACK) begin
			val_q <= val_q >> take;
		end
		if (state_q == S_PACK) begin
			cur_q <= byte_next;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_PACK && bits_next == 4'd0) begin
			ring_mem[write_q] <= byte_next;
		end
		rd_byte_s1 <= ring_mem[read_q];
	end

	always_ff @(posedge clk) begin
		if (rd_vld_s1 && (ecount_q < EMIT_CAP)) begin
			ebuf_mem[ecount_q[IW-1:0]] <= rd_byte_s1;
		end
		ebuf_rd_q <= ebuf_mem[oidx_q];
	end

endmodule

// ===== rtl/lbp_checker.sv =====
// ----------------------------------------------------------------------------
// lbp_checker
// Port-level checks of the bit packer, bound to the top level.
// ----------------------------------------------------------------------------
module lbp_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_ready,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic                          byte_valid,
	input logic [lbp_pkg::BYTE_W-1:0]    out_byte,
	input logic [lbp_pkg::SPACE_W-1:0]   space_bits,
	input logic                          last
);

	a_hold_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(byte_valid) && $stable(out_byte)
		&& $stable(space_bits) && $stable(last))
		else $error("stalled result changed");

	a_one_side: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("input ready while a result is pending");

	a_empty_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !byte_valid |-> last && (out_byte == '0))
		else $error("empty result not final or not zero");

	a_idle_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && last |=> in_ready && !out_valid)
		else $error("not ready after final transfer");

endmodule

bind lsb_first_bit_packer lbp_checker u_lbp_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_ch.valid),
	.in_ready   (in_ch.ready),
	.out_valid  (out_ch.valid),
	.out_ready  (out_ch.ready),
	.byte_valid (out_ch.byte_valid),
	.out_byte   (out_ch.out_byte),
	.space_bits (out_ch.space_bits),
	.last       (out_ch.last)
);

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the LSB-first bit packer. A local model of the
// byte ring predicts the bytes, free space and last marks of every transfer.
// The bench runs directed edge cases, a ring wrap and randomized append and
// flush traffic under several sender and receiver idling patterns.
// ----------------------------------------------------------------------------
module testbench;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned DEPTH = lbp_pkg::DEFAULT_BUFFER_DEPTH;

	typedef struct packed {
		logic                         byte_valid;
		logic [lbp_pkg::BYTE_W-1:0]   out_byte;
		logic [lbp_pkg::SPACE_W-1:0]  space_bits;
		logic                         last;
	} packer_result_t;

	logic clk = 1'b0;
	logic arst_n;

	lbp_in_if  in_ch ();
	lbp_out_if out_ch ();

	lsb_first_bit_packer u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	always #4 clk = ~clk;

	logic [lbp_pkg::BYTE_W-1:0] ring_model [DEPTH];
	int unsigned                wr_model;
	int unsigned                rd_model;
	int unsigned                free_bits_model;
	logic [lbp_pkg::BYTE_W-1:0] drained_bytes [$];
	packer_result_t             predicted_outputs [$];

	int unsigned mismatches = 0;
	int unsigned send_idle_pct = 0;
	int unsigned recv_stall_pct = 0;

	// ---------------------------------------------------------------- model

	function automatic void reset_model();
		foreach (ring_model[i])
			ring_model[i] = '0;
		wr_model = 0;
		rd_model = 0;
		free_bits_model = 8;
	endfunction

	function automatic void drain_complete_bytes();
		while (rd_model != wr_model) begin
			if (drained_bytes.size() < DEPTH)
				drained_bytes.push_back(ring_model[rd_model]);
			rd_model = (rd_model + 1) % DEPTH;
		end
	endfunction

	function automatic void insert_bits(int unsigned count,
			logic [lbp_pkg::VALUE_W-1:0] bits);
		int unsigned n;
		int unsigned take;
		int unsigned shift;
		int unsigned nxt;
		logic [15:0] merged;
		logic [15:0] mask;
		n = (count > lbp_pkg::MAX_COUNT) ? lbp_pkg::MAX_COUNT : count;
		while (n > 0) begin
			take = (free_bits_model < n) ? free_bits_model : n;
			shift = 8 - free_bits_model;
			mask = (16'd1 << take) - 16'd1;
			merged = {8'h00, ring_model[wr_model]};
			merged &= ~(mask << shift);
			merged |= (bits[15:0] & mask) << shift;
			ring_model[wr_model] = merged[7:0];
			bits = bits >> take;
			n -= take;
			free_bits_model -= take;
			if (free_bits_model == 0) begin
				nxt = (wr_model + 1) % DEPTH;
				if (nxt == rd_model)
					drain_complete_bytes();
				wr_model = nxt;
				free_bits_model = 8;
			end
		end
	endfunction

	function automatic void pack_item(logic [lbp_pkg::OP_W-1:0] op,
			logic [lbp_pkg::COUNT_W-1:0] count, logic [lbp_pkg::VALUE_W-1:0] value);
		int unsigned slots;
		int unsigned space;
		packer_result_t r;
		drained_bytes.delete();
		if (op == lbp_pkg::OP_APPEND)
			insert_bits(count, value);
		else
			drain_complete_bytes();
		slots = (rd_model + DEPTH - wr_model - 1) % DEPTH;
		space = free_bits_model + 8 * slots;
		if (space > 255)
			space = 255;
		if (drained_bytes.size() == 0) begin
			r.byte_valid = 1'b0;
			r.out_byte = '0;
			r.space_bits = space[lbp_pkg::SPACE_W-1:0];
			r.last = 1'b1;
			predicted_outputs.push_back(r);
		end else begin
			foreach (drained_bytes[k]) begin
				r.byte_valid = 1'b1;
				r.out_byte = drained_bytes[k];
				r.space_bits = space[lbp_pkg::SPACE_W-1:0];
				r.last = (k == drained_bytes.size() - 1);
				predicted_outputs.push_back(r);
			end
		end
	endfunction

	// ------------------------------------------------------------- checking

	task automatic report_mismatch(input string msg);
		mismatches++;
		if (mismatches <= 40)
			$display("[%0t] MISMATCH: %s", $realtime, msg);
	endtask

	always @(posedge clk) begin
		out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	always @(posedge clk) begin
		packer_result_t want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (predicted_outputs.size() == 0) begin
				report_mismatch($sformatf("unexpected transfer byte=%02h space=%0d last=%0b",
					out_ch.out_byte, out_ch.space_bits, out_ch.last));
			end else begin
				want = predicted_outputs.pop_front();
				if (out_ch.byte_valid !== want.byte_valid)
					report_mismatch($sformatf("byte_valid got %0b want %0b",
						out_ch.byte_valid, want.byte_valid));
				if (out_ch.out_byte !== want.out_byte)
					report_mismatch($sformatf("out_byte got %02h want %02h",
						out_ch.out_byte, want.out_byte));
				if (out_ch.space_bits !== want.space_bits)
					report_mismatch($sformatf("space_bits got %0d want %0d",
						out_ch.space_bits, want.space_bits));
				if (out_ch.last !== want.last)
					report_mismatch($sformatf("last got %0b want %0b",
						out_ch.last, want.last));
			end
		end
	end

	// ------------------------------------------------------------- stimulus

	task automatic send_item(input logic [lbp_pkg::OP_W-1:0] op,
			input logic [lbp_pkg::COUNT_W-1:0] count,
			input logic [lbp_pkg::VALUE_W-1:0] value);
		while ($urandom_range(99) < send_idle_pct) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.op <= op;
		in_ch.bit_count <= count;
		in_ch.field_value <= value;
		do
			@(posedge clk);
		while (!in_ch.ready);
		pack_item(op, count, value);
	endtask

	task automatic hold_until_drained();
		int unsigned waited;
		in_ch.valid <= 1'b0;
		waited = 0;
		while (predicted_outputs.size() != 0 && waited < 20000) begin
			@(posedge clk);
			waited++;
		end
	endtask

	function automatic logic [lbp_pkg::COUNT_W-1:0] random_count();
		int unsigned pick;
		pick = $urandom_range(99);
		if (pick < 60)
			return lbp_pkg::COUNT_W'($urandom_range(16, 0));
		else if (pick < 85)
			return lbp_pkg::COUNT_W'($urandom_range(63, 17));
		else if (pick < 93)
			return lbp_pkg::COUNT_W'(lbp_pkg::MAX_COUNT);
		else
			return lbp_pkg::COUNT_W'($urandom_range(127, 65));
	endfunction

	task automatic send_random_item();
		logic [lbp_pkg::OP_W-1:0] op;
		op = ($urandom_range(99) < 12) ? lbp_pkg::OP_FLUSH : lbp_pkg::OP_APPEND;
		send_item(op, random_count(), {$urandom, $urandom});
	endtask

	// ---------------------------------------------------------------- tests

	task automatic test_empty_items();
		send_item(lbp_pkg::OP_FLUSH, '0, '0);
		send_item(lbp_pkg::OP_APPEND, '0, '1);
		send_item(lbp_pkg::OP_FLUSH, '1, '1);
	endtask

	task automatic test_field_extremes();
		send_item(lbp_pkg::OP_APPEND, 7'd1, 64'h1);
		send_item(lbp_pkg::OP_APPEND, 7'd7, 64'hFFFF_FFFF_FFFF_FF7E);
		send_item(lbp_pkg::OP_APPEND, 7'd8, 64'h0000_0000_0000_00A5);
		send_item(lbp_pkg::OP_FLUSH, '0, '0);
		send_item(lbp_pkg::OP_APPEND, 7'd3, 64'h5);
		send_item(lbp_pkg::OP_APPEND, 7'd64, '1);
		send_item(lbp_pkg::OP_FLUSH, 7'd64, 64'h8000_0000_0000_0000);
		send_item(lbp_pkg::OP_APPEND, 7'd127, 64'hA5A5_5A5A_0F0F_F0F0);
		send_item(lbp_pkg::OP_APPEND, 7'd65, 64'h0123_4567_89AB_CDEF);
		send_item(lbp_pkg::OP_FLUSH, '0, '0);
		send_item(lbp_pkg::OP_APPEND, 7'd64, '0);
		send_item(lbp_pkg::OP_FLUSH, '0, '0);
	endtask

	task automatic test_ring_wrap();
		send_item(lbp_pkg::OP_APPEND, 7'd64, 64'hFEDC_BA98_7654_3210);
		send_item(lbp_pkg::OP_APPEND, 7'd64, 64'h0F1E_2D3C_4B5A_6978);
		send_item(lbp_pkg::OP_APPEND, 7'd64, 64'h8877_6655_4433_2211);
		send_item(lbp_pkg::OP_APPEND, 7'd5, 64'h1B);
		send_item(lbp_pkg::OP_APPEND, 7'd64, 64'hC3C3_3C3C_9696_6969);
		send_item(lbp_pkg::OP_APPEND, 7'd64, '1);
		send_item(lbp_pkg::OP_FLUSH, '0, '0);
		send_item(lbp_pkg::OP_FLUSH, '0, '0);
	endtask

	task automatic test_pause_until_drained();
		repeat (6)
			send_random_item();
		hold_until_drained();
		send_item(lbp_pkg::OP_APPEND, 7'd64, {$urandom, $urandom});
		send_item(lbp_pkg::OP_FLUSH, '0, '0);
	endtask

	task automatic test_random_traffic(input int unsigned idle_pct, input int unsigned stall_pct,
			input int unsigned items);
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		repeat (items)
			send_random_item();
	endtask

	// ----------------------------------------------------------------- main

	initial begin
		arst_n <= 1'b0;
		in_ch.valid <= 1'b0;
		in_ch.op <= lbp_pkg::OP_APPEND;
		in_ch.bit_count <= '0;
		in_ch.field_value <= '0;
		reset_model();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_items();
		test_field_extremes();
		test_ring_wrap();
		test_random_traffic(0, 0, 105);
		test_pause_until_drained();
		test_random_traffic(51, 0, 105);
		test_random_traffic(0, 51, 105);
		test_random_traffic(24, 24, 105);
		test_random_traffic(0, 0, 10);

		hold_until_drained();
		repeat (40) @(posedge clk);
		if (predicted_outputs.size() != 0)
			report_mismatch($sformatf("%0d expected transfers never arrived",
				predicted_outputs.size()));
		if (mismatches == 0)
			$display("testbench passed");
		else
			$display("testbench failed");
		$finish;
	end

	initial begin
		#4_000_000;
		$display("testbench failed");
		$finish;
	end

endmodule
